>>> src/svptm_pkg.sv
// Shared constants, codes and a helper function of the Sv39 page table manager.
package svptm_pkg;

    localparam int TABLE_FRAMES = 16;
    localparam int LEVELS       = 3;

    localparam int ENTRY_W   = 64;
    localparam int IDX_W     = 9;
    localparam int FRAME_W   = $clog2(TABLE_FRAMES);
    localparam int NF_W      = $clog2(TABLE_FRAMES + 1);
    localparam int ADDR_W    = FRAME_W + IDX_W;
    localparam int DEPTH     = TABLE_FRAMES * (1 << IDX_W);
    localparam int PPN_W     = 44;
    localparam int VA_W      = 39;
    localparam int VPN_W     = 27;
    localparam int PA_W      = 56;
    localparam int FLAGS_W   = 10;
    localparam int COUNT_W   = 12;
    localparam int ACT_W     = 3;
    localparam int STATUS_W  = 3;
    localparam int LEVEL_W   = 2;

    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 136;

    localparam int OFF_W = 12 + 9 * (3 - LEVELS);
    localparam logic [PA_W-1:0] OFF_MASK = (PA_W'(1) << OFF_W) - PA_W'(1);

    localparam logic [ACT_W-1:0] ACT_TRANSLATE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_MAP       = 3'd1;
    localparam logic [ACT_W-1:0] ACT_UNMAP     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SET_FLAGS = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PROBE     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_MAPPED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_POINTER = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OCCUPIED    = 3'd5;

    localparam logic [ENTRY_W-1:0] PTE_V = 64'h01;
    localparam logic [ENTRY_W-1:0] PTE_A = 64'h40;
    localparam logic [ENTRY_W-1:0] PTE_D = 64'h80;

    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [LEVEL_W-1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

>>> src/svptm_table_ram.sv
// Single-port-write, registered-read memory that holds the page table pool.
module svptm_table_ram (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [svptm_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [svptm_pkg::ENTRY_W-1:0] wr_data,
    input  logic [svptm_pkg::ADDR_W-1:0]  rd_addr,
    output logic [svptm_pkg::ENTRY_W-1:0] rd_data
);
    import svptm_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/sv39_page_table_manager.sv
// Top level of the Sv39 page table manager: request sequencer and table walker.
//
// Requests arrive on the s_ stream channel, one transaction per request, with
// the action code in s_tuser. Each request yields exactly one result
// transaction on the m_ channel. The user must write the table base through
// cfg_wr_en and cfg_wr_data only while no request is in flight; the block
// itself does not enforce this. A request is handled one at a time. Each
// table level of a walk takes a memory read state and an evaluation state.
// Each new table frame that map hands out is zeroed entry by entry and then
// linked into its parent entry. Probe repeats the walk once per page.
// After reset the block sweeps all 8192 table entries to zero, one per cycle,
// and holds s_tready low until the sweep is done.
// A finished result sits in an output register; while the receiver stalls,
// the next request can still be accepted and walked, and its result waits
// until the output register is free.
module sv39_page_table_manager (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [svptm_pkg::PPN_W-1:0]     cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // virt_address, phys_page, pte_flags, page_count
    input  logic [svptm_pkg::S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [svptm_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status, phys_addr, leaf_entry, free_count
    output logic [svptm_pkg::M_TDATA_W-1:0] m_tdata
);
    import svptm_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_ZERO  = 7'b0010000,
        S_LINK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]      zero_idx_reg, zero_idx_next;
    logic [PPN_W-1:0]      base_reg;
    logic [ACT_W-1:0]      act_reg, act_next;
    logic [VA_W-1:0]       va_reg, va_next;
    logic [VA_W-1:0]       walk_va_reg, walk_va_next;
    logic [PPN_W-1:0]      ppn_reg, ppn_next;
    logic [FLAGS_W-1:0]    flags_reg, flags_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [COUNT_W-1:0]    freec_reg, freec_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic [FRAME_W-1:0]    frame_reg, frame_next;
    logic [NF_W-1:0]       next_free_reg, next_free_next;
    logic [FRAME_W-1:0]    new_frame_reg, new_frame_next;
    logic [ADDR_W-1:0]     link_addr_reg, link_addr_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [PA_W-1:0]       res_phys_reg, res_phys_next;
    logic [ENTRY_W-1:0]    res_leaf_reg, res_leaf_next;
    logic [COUNT_W-1:0]    res_free_reg, res_free_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [ENTRY_W-1:0]    mem_rdata;

    logic [ADDR_W-1:0]     cur_addr;
    logic [PPN_W-1:0]      rel;
    logic [PPN_W-1:0]      ent_ppn;
    logic                  ent_v;
    logic                  is_leaf;
    logic [COUNT_W-1:0]    freec_inc;
    logic [VPN_W-1:0]      page_next;
    logic [ENTRY_W-1:0]    map_leaf;
    logic [ENTRY_W-1:0]    flag_leaf;

    svptm_table_ram u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign cur_addr  = {frame_reg, level_index(walk_va_reg, level_reg)};
    assign ent_ppn   = mem_rdata[53:10];
    assign ent_v     = mem_rdata[0];
    assign rel       = ent_ppn - base_reg;
    assign is_leaf   = (level_reg == LEVEL_W'(LEVELS));
    assign freec_inc = freec_reg + COUNT_W'(1);
    assign page_next = va_reg[38:12] + VPN_W'(freec_inc);
    assign map_leaf  = {10'd0, ppn_reg, flags_reg} | PTE_D | PTE_A | PTE_V;
    assign flag_leaf = {10'd0, ent_ppn, flags_reg};
    assign mem_raddr = cur_addr;

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        zero_idx_next   = zero_idx_reg;
        act_next        = act_reg;
        va_next         = va_reg;
        walk_va_next    = walk_va_reg;
        ppn_next        = ppn_reg;
        flags_next      = flags_reg;
        count_next      = count_reg;
        freec_next      = freec_reg;
        level_next      = level_reg;
        frame_next      = frame_reg;
        next_free_next  = next_free_reg;
        new_frame_next  = new_frame_reg;
        link_addr_next  = link_addr_reg;
        res_status_next = res_status_reg;
        res_phys_next   = res_phys_reg;
        res_leaf_next   = res_leaf_reg;
        res_free_next   = res_free_reg;
        m_valid_next    = m_valid_reg & ~m_tready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_addr;
        mem_wdata       = '0;

        case (state_reg)
            S_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next        = s_tuser;
                    va_next         = s_tdata[38:0];
                    walk_va_next    = s_tdata[38:0];
                    ppn_next        = s_tdata[82:39];
                    flags_next      = s_tdata[92:83];
                    count_next      = s_tdata[104:93];
                    freec_next      = '0;
                    level_next      = LEVEL_W'(1);
                    frame_next      = '0;
                    res_status_next = ST_OK;
                    res_phys_next   = '0;
                    res_leaf_next   = '0;
                    res_free_next   = '0;
                    if (s_tuser > ACT_PROBE ||
                        (s_tuser == ACT_PROBE && s_tdata[104:93] == '0)) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (!is_leaf) begin
                    if (!ent_v) begin
                        if (act_reg == ACT_MAP) begin
                            if (next_free_reg >= NF_W'(TABLE_FRAMES)) begin
                                res_status_next = ST_EXHAUSTED;
                                state_next      = S_DONE;
                            end else begin
                                new_frame_next = next_free_reg[FRAME_W-1:0];
                                next_free_next = next_free_reg + NF_W'(1);
                                link_addr_next = cur_addr;
                                zero_idx_next  = '0;
                                state_next     = S_ZERO;
                            end
                        end else if (act_reg == ACT_PROBE) begin
                            state_next = S_DONE;
                        end else begin
                            res_status_next = ST_NOT_MAPPED;
                            state_next      = S_DONE;
                        end
                    end else if (rel >= PPN_W'(TABLE_FRAMES)) begin
                        res_status_next = ST_BAD_POINTER;
                        res_free_next   = (act_reg == ACT_PROBE) ? freec_reg : '0;
                        state_next      = S_DONE;
                    end else begin
                        frame_next = rel[FRAME_W-1:0];
                        level_next = level_reg + LEVEL_W'(1);
                        state_next = S_READ;
                    end
                end else begin
                    state_next = S_DONE;
                    case (act_reg)
                        ACT_TRANSLATE: begin
                            res_leaf_next = mem_rdata;
                            if (ent_v) begin
                                res_phys_next = ({ent_ppn, 12'd0} & ~OFF_MASK) |
                                                ({17'd0, va_reg} & OFF_MASK);
                            end else begin
                                res_status_next = ST_NOT_MAPPED;
                            end
                        end
                        ACT_MAP: begin
                            if (ent_v) begin
                                res_status_next = ST_ALREADY;
                                res_leaf_next   = mem_rdata;
                            end else begin
                                mem_we        = 1'b1;
                                mem_wdata     = map_leaf;
                                res_leaf_next = map_leaf;
                            end
                        end
                        ACT_UNMAP: begin
                            res_leaf_next = mem_rdata;
                            if (ent_v) begin
                                mem_we = 1'b1;
                            end else begin
                                res_status_next = ST_NOT_MAPPED;
                            end
                        end
                        ACT_SET_FLAGS: begin
                            if (ent_v) begin
                                mem_we        = 1'b1;
                                mem_wdata     = flag_leaf;
                                res_leaf_next = flag_leaf;
                            end else begin
                                res_status_next = ST_NOT_MAPPED;
                                res_leaf_next   = mem_rdata;
                            end
                        end
                        default: begin
                            if (mem_rdata != '0) begin
                                res_status_next = ST_OCCUPIED;
                                res_free_next   = freec_reg;
                            end
                        end
                    endcase
                end
                if (act_reg == ACT_PROBE && state_next == S_DONE &&
                    res_status_next == ST_OK) begin
                    if (freec_inc == count_reg) begin
                        res_free_next = count_reg;
                    end else begin
                        freec_next   = freec_inc;
                        walk_va_next = {page_next, 12'd0};
                        level_next   = LEVEL_W'(1);
                        frame_next   = '0;
                        state_next   = S_READ;
                    end
                end
            end
            S_ZERO: begin
                mem_we        = 1'b1;
                mem_waddr     = {new_frame_reg, zero_idx_reg};
                zero_idx_next = zero_idx_reg + IDX_W'(1);
                if (zero_idx_reg == '1) begin
                    state_next = S_LINK;
                end
            end
            S_LINK: begin
                mem_we     = 1'b1;
                mem_waddr  = link_addr_reg;
                mem_wdata  = {10'd0, base_reg + PPN_W'(new_frame_reg), 10'd0} | PTE_V;
                frame_next = new_frame_reg;
                level_next = level_reg + LEVEL_W'(1);
                state_next = S_READ;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, res_free_reg, res_leaf_reg, res_phys_reg,
                                    res_status_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            next_free_reg <= NF_W'(1);
            base_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            next_free_reg <= next_free_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        zero_idx_reg   <= zero_idx_next;
        act_reg        <= act_next;
        va_reg         <= va_next;
        walk_va_reg    <= walk_va_next;
        ppn_reg        <= ppn_next;
        flags_reg      <= flags_next;
        count_reg      <= count_next;
        freec_reg      <= freec_next;
        level_reg      <= level_next;
        frame_reg      <= frame_next;
        new_frame_reg  <= new_frame_next;
        link_addr_reg  <= link_addr_next;
        res_status_reg <= res_status_next;
        res_phys_reg   <= res_phys_next;
        res_leaf_reg   <= res_leaf_next;
        res_free_reg   <= res_free_next;
        m_data_reg     <= m_data_next;
    end

endmodule

>>> src/svptm_checker.sv
// Port-level assertions for the Sv39 page table manager and their bind.
module svptm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [svptm_pkg::M_TDATA_W-1:0] m_tdata
);
    import svptm_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid && !s_tready)
        else $error("outputs active right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request accepted while one is in progress");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= ST_OCCUPIED)
        else $error("status code out of range");

    a_phys_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[58:3] == '0)
        else $error("physical address nonzero on failed request");

endmodule

bind sv39_page_table_manager svptm_checker u_svptm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
